@@ design/circular_first_fit_slot_allocator_assert.svh @@
// Assertion macros shared by the allocator modules.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef CIRCULAR_FIRST_FIT_SLOT_ALLOCATOR_ASSERT_SVH
`define CIRCULAR_FIRST_FIT_SLOT_ALLOCATOR_ASSERT_SVH

// Property that must hold in every cycle outside of reset.
`define CFFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define CFFSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cffsa_pkg.sv @@
`default_nettype none

package cffsa_pkg;

  // Store geometry
  localparam int unsigned MAX_SLOTS = 64;
  localparam int unsigned SLOT_W    = 6;   // slot index width
  localparam int unsigned CNT_W     = 7;   // count width, holds MAX_SLOTS itself

  // Request kinds
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Which result to capture at the end of a request
  typedef enum logic [1:0] {
    RES_OK,
    RES_FREE,
    RES_FAIL
  } res_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     load_req;       // capture a new request
    logic     mod_step;       // one subtract step of start mod n
    logic     scan_init;      // start the free-run scan
    logic     scan_step;      // test one slot of the scan
    logic     walk_init;      // start a mark/clear walk
    logic     walk_from_run;  // walk begins at the found run, else at start
    logic     walk_step;      // write one slot of the walk
    logic     walk_set;       // value written by the walk
    logic     set_res;        // capture the result
    res_sel_e res_sel;
    logic     load_out;       // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op_free;
    logic mod_done;
    logic cnt_zero;
    logic too_big;
    logic found;
    logic exhausted;
    logic walk_last;
  } sts_t;

endpackage

`default_nettype wire

@@ design/cffsa_datapath.sv @@
`default_nettype none

module cffsa_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cffsa_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                        req_op_i,
  input  logic [cffsa_pkg::SLOT_W-1:0] req_start_i,
  input  logic [cffsa_pkg::CNT_W-1:0]  req_count_i,
  input  cffsa_pkg::cmd_t             cmd_i,
  output cffsa_pkg::sts_t             sts_o,
  output logic [cffsa_pkg::CNT_W-1:0]  out_value_o,
  output logic                        out_failed_o
);

  import cffsa_pkg::*;

  logic [CNT_W-1:0]     total_slots_q;
  logic [CNT_W-1:0]     total_slots_d;
  logic [MAX_SLOTS-1:0] used_q;
  logic                 op_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SLOT_W-1:0]    sm_q;
  logic [SLOT_W-1:0]    cur_q;
  logic [SLOT_W-1:0]    run_pos_q;
  logic [CNT_W-1:0]     ro_q;
  logic [CNT_W-1:0]     len_q;
  logic [SLOT_W-1:0]    wp_q;
  logic [CNT_W-1:0]     wn_q;
  logic [CNT_W-1:0]     res_q;
  logic                 fail_q;
  logic [CNT_W-1:0]     out_value_q;
  logic                 out_failed_q;

  logic [CNT_W-1:0]     span;
  logic                 used_bit;
  logic [SLOT_W-1:0]    cur_nxt;
  logic [SLOT_W-1:0]    wp_nxt;
  logic [CNT_W:0]       pass_len;
  logic [CNT_W-1:0]     len_inc;

  // Config write, clamped to 1..MAX_SLOTS
  always_comb begin
    total_slots_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      total_slots_d = CNT_W'(1);
    end else if (cfg_wdata_i > CNT_W'(MAX_SLOTS)) begin
      total_slots_d = CNT_W'(MAX_SLOTS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_slots_q <= CNT_W'(MAX_SLOTS);
    end else if (cfg_we_i) begin
      total_slots_q <= total_slots_d;
    end
  end

  // Scan and walk helpers
  assign span     = (cnt_q > total_slots_q) ? total_slots_q : cnt_q;
  assign used_bit = used_q[cur_q];
  assign cur_nxt  = (({1'b0, cur_q} + CNT_W'(1)) == total_slots_q) ? '0 : cur_q + SLOT_W'(1);
  assign wp_nxt   = (({1'b0, wp_q} + CNT_W'(1)) == total_slots_q) ? '0 : wp_q + SLOT_W'(1);
  // offset of the slot under test, plus one
  assign pass_len = {1'b0, ro_q} + {1'b0, len_q} + (CNT_W+1)'(1);
  assign len_inc  = len_q + CNT_W'(1);

  // Status
  assign sts_o.op_free   = (op_q == OP_FREE);
  assign sts_o.mod_done  = ({1'b0, sm_q} < total_slots_q);
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.too_big   = (cnt_q > total_slots_q);
  assign sts_o.found     = !used_bit && (len_inc == cnt_q);
  assign sts_o.exhausted = used_bit && (pass_len >= {1'b0, total_slots_q});
  assign sts_o.walk_last = ((wn_q + CNT_W'(1)) == span);

  // Slot bitmap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.walk_step) begin
      used_q[wp_q] <= cmd_i.walk_set;
    end
  end

  // Request, scan and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= req_op_i;
      cnt_q <= req_count_i;
      sm_q  <= req_start_i;
    end else if (cmd_i.mod_step && !sts_o.mod_done) begin
      sm_q <= sm_q - total_slots_q[SLOT_W-1:0];
    end

    if (cmd_i.scan_init) begin
      cur_q     <= sm_q;
      run_pos_q <= sm_q;
      ro_q      <= '0;
      len_q     <= '0;
    end else if (cmd_i.scan_step) begin
      cur_q <= cur_nxt;
      if (used_bit) begin
        // run broken: next candidate is the slot after this one
        run_pos_q <= cur_nxt;
        ro_q      <= pass_len[CNT_W-1:0];
        len_q     <= '0;
      end else begin
        len_q <= len_inc;
      end
    end

    if (cmd_i.walk_init) begin
      wp_q <= cmd_i.walk_from_run ? run_pos_q : sm_q;
      wn_q <= '0;
    end else if (cmd_i.walk_step) begin
      wp_q <= wp_nxt;
      wn_q <= wn_q + CNT_W'(1);
    end

    if (cmd_i.set_res) begin
      case (cmd_i.res_sel)
        RES_OK: begin
          res_q  <= {1'b0, run_pos_q};
          fail_q <= 1'b0;
        end
        RES_FREE: begin
          res_q  <= cnt_q;
          fail_q <= 1'b0;
        end
        default: begin
          res_q  <= '0;
          fail_q <= 1'b1;
        end
      endcase
    end

    if (cmd_i.load_out) begin
      out_value_q  <= res_q;
      out_failed_q <= fail_q;
    end
  end

  assign out_value_o  = out_value_q;
  assign out_failed_o = out_failed_q;

  `include "circular_first_fit_slot_allocator_assert.svh"

  `CFFSA_ASSERT(a_scan_in_range, cmd_i.scan_step |-> ({1'b0, cur_q} < total_slots_q), "scan pointer outside the slots in use")
  `CFFSA_ASSERT(a_mark_only_free, (cmd_i.walk_step && cmd_i.walk_set) |-> !used_q[wp_q], "allocation marks a slot already used")
  `CFFSA_ASSERT(a_walk_bound, cmd_i.walk_step |-> (wn_q < span), "walk runs past its length")

endmodule

`default_nettype wire

@@ design/cffsa_ctrl.sv @@
`default_nettype none

module cffsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  cffsa_pkg::sts_t sts_i,
  output cffsa_pkg::cmd_t cmd_o
);

  import cffsa_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_vld_q;
  logic       out_vld_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!sts_i.mod_done) begin
          cmd_o.mod_step = 1'b1;
        end else if (sts_i.op_free) begin
          if (sts_i.cnt_zero) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_FREE;
            state_d       = ST_RESP;
          end else begin
            cmd_o.walk_init = 1'b1;
            state_d         = ST_CLEAR;
          end
        end else if (sts_i.too_big) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_FAIL;
          state_d       = ST_RESP;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.cnt_zero) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_OK;
          state_d       = ST_RESP;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.found) begin
            cmd_o.walk_init     = 1'b1;
            cmd_o.walk_from_run = 1'b1;
            state_d             = ST_MARK;
          end else if (sts_i.exhausted) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_sel = RES_FAIL;
            state_d       = ST_RESP;
          end
        end
      end
      ST_MARK: begin
        cmd_o.walk_step = 1'b1;
        cmd_o.walk_set  = 1'b1;
        if (sts_i.walk_last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_OK;
          state_d       = ST_RESP;
        end
      end
      ST_CLEAR: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_sel = RES_FREE;
          state_d       = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

  `include "circular_first_fit_slot_allocator_assert.svh"

  `CFFSA_ASSERT(a_no_overwrite, cmd_o.load_out |-> (!out_vld_q || out_ready_i), "result overwrites an untaken result")
  `CFFSA_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, state_q == ST_MOD, "accepted request did not start")
  `CFFSA_ASSERT(a_one_action, $onehot0({cmd_o.mod_step, cmd_o.walk_step, cmd_o.load_out, cmd_o.load_req}), "conflicting datapath commands")

endmodule

`default_nettype wire

@@ design/circular_first_fit_slot_allocator.sv @@
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tuser: operation; tdata: start_index, slot_count
// m_axis    out  tvalid/tready           tuser: failed; tdata: result_value
// cfg       in   cfg_we_i (no wait)      cfg_wdata_i: total_slots
//
// One request at a time. With n slots in use and start s, a request is accepted,
// the start is wrapped by subtracting n until it is below n, then a store tests up
// to 2n-1 slots and marks slot_count slots, a free clears min(count,n) slots, and
// the result goes into the output register, which stalls while m_axis holds a result.
// The bitmap is cleared by reset at once; no clearing pass.
// A new request is accepted while the previous result still waits on m_axis.
`default_nettype none

module circular_first_fit_slot_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cffsa_pkg::CNT_W-1:0] cfg_wdata_i,   // total_slots
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // [5:0] start_index, [12:6] slot_count
  input  logic                       s_axis_tuser,  // [0] operation
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [6:0] result_value
  output logic                       m_axis_tuser   // [0] failed
);

  import cffsa_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] out_value;
  logic             out_failed;

  cffsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cffsa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_op_i     (s_axis_tuser),
    .req_start_i  (s_axis_tdata[SLOT_W-1:0]),
    .req_count_i  (s_axis_tdata[SLOT_W+CNT_W-1:SLOT_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_value_o  (out_value),
    .out_failed_o (out_failed)
  );

  assign m_axis_tdata = {1'b0, out_value};
  assign m_axis_tuser = out_failed;

endmodule

`default_nettype wire

@@ bench/tb_circular_first_fit_slot_allocator.sv @@
`timescale 1ns / 1ps

module tb_circular_first_fit_slot_allocator;
  import cffsa_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;   // cycles with no transaction at all
  localparam int unsigned DRAIN_WAIT = 300;    // worst request: wrap + scan + mark
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_REQS = 143;
  localparam int unsigned DIR_ROWS   = 20;

  // One allocator answer
  typedef struct packed {
    logic [CNT_W-1:0] value;
    logic             failed;
  } alloc_result_t;

  // Directed request, with a hand-written answer where typed is set
  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] start;
    logic [CNT_W-1:0]  count;
    logic              typed;
    logic [CNT_W-1:0]  value;
    logic              failed;
  } req_row_t;

  // Runs with 64 slots from reset: wraps, full store, oversize, zero counts
  localparam req_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_STORE, 6'd0,  7'd1,   1'b1, 7'd0,   1'b0},
    '{OP_STORE, 6'd63, 7'd1,   1'b1, 7'd63,  1'b0},
    '{OP_STORE, 6'd62, 7'd3,   1'b0, 7'd0,   1'b0},
    '{OP_STORE, 6'd10, 7'd0,   1'b1, 7'd10,  1'b0},
    '{OP_STORE, 6'd5,  7'd65,  1'b1, 7'd0,   1'b1},
    '{OP_STORE, 6'd0,  7'd127, 1'b1, 7'd0,   1'b1},
    '{OP_FREE,  6'd62, 7'd127, 1'b1, 7'd127, 1'b0},
    '{OP_STORE, 6'd0,  7'd64,  1'b1, 7'd0,   1'b0},
    '{OP_STORE, 6'd3,  7'd1,   1'b1, 7'd0,   1'b1},
    '{OP_FREE,  6'd63, 7'd2,   1'b1, 7'd2,   1'b0},
    '{OP_STORE, 6'd10, 7'd2,   1'b0, 7'd0,   1'b0},
    '{OP_FREE,  6'd0,  7'd0,   1'b1, 7'd0,   1'b0},
    '{OP_FREE,  6'd0,  7'd64,  1'b1, 7'd64,  1'b0},
    '{OP_STORE, 6'd63, 7'd64,  1'b1, 7'd63,  1'b0},
    '{OP_FREE,  6'd32, 7'd16,  1'b0, 7'd0,   1'b0},
    '{OP_STORE, 6'd0,  7'd16,  1'b0, 7'd0,   1'b0},
    '{OP_FREE,  6'd0,  7'd64,  1'b0, 7'd0,   1'b0},
    '{OP_STORE, 6'd21, 7'd42,  1'b0, 7'd0,   1'b0},
    '{OP_STORE, 6'd42, 7'd21,  1'b0, 7'd0,   1'b0},
    '{OP_FREE,  6'd0,  7'd64,  1'b0, 7'd0,   1'b0}
  };

  // Slot counts per phase, extremes and out-of-range values among them
  localparam logic [CNT_W-1:0] PHASE_SLOTS [NUM_PHASES] = '{
    7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd5, 7'd24, 7'd33, 7'd64
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CNT_W-1:0]  cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [5:0] start_index, [12:6] slot_count
  logic              s_axis_tuser;   // [0] operation
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;   // [6:0] result_value
  logic              m_axis_tuser;   // [0] failed

  // Predictor state
  logic [MAX_SLOTS-1:0] slot_map;
  logic [CNT_W-1:0]     slots_reg;
  alloc_result_t        pending_results [$];

  bit          no_idle;
  int unsigned fail_count;
  int unsigned idle_cycles;

  circular_first_fit_slot_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Register value to slots actually in use: 0 acts as 1, above max clamps
  function automatic int active_slots(logic [CNT_W-1:0] reg_val);
    if (reg_val == '0) return 1;
    if (int'(reg_val) > int'(MAX_SLOTS)) return int'(MAX_SLOTS);
    return int'(reg_val);
  endfunction

  // First-fit search or free over the circular bitmap; updates slot_map
  function automatic alloc_result_t predict_request(logic op, logic [SLOT_W-1:0] start_in,
                                                    logic [CNT_W-1:0] count);
    int            n;
    int            start;
    int            span;
    int            pos;
    bit            fits;
    alloc_result_t res;
    n = active_slots(slots_reg);
    start = int'(start_in) % n;
    res.value = '0;
    res.failed = 1'b0;
    if (op == OP_FREE) begin
      span = (int'(count) > n) ? n : int'(count);
      for (int j = 0; j < span; j++) slot_map[(start + j) % n] = 1'b0;
      res.value = count;
      return res;
    end
    res.failed = 1'b1;
    if (int'(count) <= n) begin
      for (int i = 0; i < n; i++) begin
        pos = (start + i) % n;
        fits = 1'b1;
        for (int j = 0; j < int'(count); j++) begin
          if (slot_map[(pos + j) % n]) fits = 1'b0;
        end
        if (fits) begin
          for (int j = 0; j < int'(count); j++) slot_map[(pos + j) % n] = 1'b1;
          res.value = pos[CNT_W-1:0];
          res.failed = 1'b0;
          return res;
        end
      end
    end
    return res;
  endfunction

  // Drive one request, then record its expected answer once accepted
  task automatic send_request(input logic op, input logic [SLOT_W-1:0] start,
                              input logic [CNT_W-1:0] count, input logic typed,
                              input alloc_result_t typed_res);
    int            gap;
    alloc_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, count, start};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pred = predict_request(op, start, count);
    pending_results.insert(pending_results.size(), typed ? typed_res : pred);
  endtask

  // Stop sending and let every outstanding answer come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slots(input logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    slots_reg    = value;
  endtask

  // Request side: reset, directed table, then random phases
  initial begin
    logic [CNT_W-1:0]  phase_val;
    logic              op;
    logic [SLOT_W-1:0] start;
    logic [CNT_W-1:0]  count;
    alloc_result_t     typed_res;
    int                n;
    int                roll;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    slot_map       = '0;
    slots_reg      = 7'd64;
    no_idle        = 1'b0;
    fail_count     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      typed_res.value  = DIRECTED[r].value;
      typed_res.failed = DIRECTED[r].failed;
      send_request(DIRECTED[r].op, DIRECTED[r].start, DIRECTED[r].count,
                   DIRECTED[r].typed, typed_res);
    end
    typed_res = '0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      phase_val = (p == 7) ? 7'($urandom_range(1, 64)) : PHASE_SLOTS[p];
      write_slots(phase_val);
      no_idle = (p == 2 || p == 7);
      n = active_slots(slots_reg);
      for (int k = 0; k < PHASE_REQS; k++) begin
        // hold off once mid-phase until every answer is back
        if (p == 5 && k == 70) begin
          s_axis_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
        end
        roll = $urandom_range(0, 99);
        op = (roll < 55) ? OP_STORE : OP_FREE;
        roll = $urandom_range(0, 99);
        if (roll < 70) count = 7'($urandom_range(0, (n < 8) ? n : 8));
        else if (roll < 92) count = 7'($urandom_range(0, n));
        else count = 7'($urandom_range(0, 127));
        start = 6'($urandom_range(0, 63));
        send_request(op, start, count, 1'b0, typed_res);
      end
    end

    // Final drain, then the verdict
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random backpressure per transaction
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Compare each answer with the oldest expectation
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_value %0d failed %0d",
               m_axis_tdata[CNT_W-1:0], m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[CNT_W-1:0] !== want.value) begin
          $error("result_value: expected %0d, actual %0d", want.value,
                 m_axis_tdata[CNT_W-1:0]);
          fail_count++;
        end
        if (m_axis_tuser !== want.failed) begin
          $error("failed: expected %0d, actual %0d", want.failed, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

@@ sim.f @@
+incdir+design
design/cffsa_pkg.sv
design/cffsa_datapath.sv
design/cffsa_ctrl.sv
design/circular_first_fit_slot_allocator.sv
bench/tb_circular_first_fit_slot_allocator.sv
